// ===== sv/tia_pkg.sv =====
// Shared types and codes for the typed integer ALU
`timescale 1ns / 1ps
package tia_pkg;
  localparam int unsigned OpW   = 4;
  localparam int unsigned TrapW = 3;
  localparam int unsigned MaxW  = 64;

  localparam logic [OpW-1:0] OP_ADD = 4'd0;
  localparam logic [OpW-1:0] OP_SUB = 4'd1;
  localparam logic [OpW-1:0] OP_MUL = 4'd2;
  localparam logic [OpW-1:0] OP_DIV = 4'd3;
  localparam logic [OpW-1:0] OP_MOD = 4'd4;
  localparam logic [OpW-1:0] OP_LT  = 4'd5;
  localparam logic [OpW-1:0] OP_GT  = 4'd6;
  localparam logic [OpW-1:0] OP_EQ  = 4'd7;
  localparam logic [OpW-1:0] OP_NEG = 4'd8;

  localparam logic [TrapW-1:0] T_OK        = 3'd0;
  localparam logic [TrapW-1:0] T_TOO_LARGE = 3'd1;
  localparam logic [TrapW-1:0] T_NEG_TO_U  = 3'd2;
  localparam logic [TrapW-1:0] T_DIV_ZERO  = 3'd3;
  localparam logic [TrapW-1:0] T_MOD_ZERO  = 3'd4;
  localparam logic [TrapW-1:0] T_U_UNDER   = 3'd5;
  localparam logic [TrapW-1:0] T_MINUS_U   = 3'd6;
  localparam logic [TrapW-1:0] T_BAD_OP    = 3'd7;

  // per-word control carried down the cell chain
  typedef struct packed {
    logic             valid;
    logic [OpW-1:0]   mode;
    logic             is_signed;
    logic             neg_q;
    logic             neg_r;
    logic [TrapW-1:0] trap;
  } tia_ctl_t;
endpackage

// ===== sv/typed_integer_alu.sv =====
// Top level: typed integer ALU built as a chain of step cells
//
// channel | dir | handshake         | payload
// in_     | in  | tvalid/tready     | tuser={right_is_signed,left_is_signed}, tdata
// out_    | out | tvalid/tready     | tuser=result_is_signed, tdata
//
// From input accept to output a word passes one entry register, one cell
// per operand bit (each cell does one divide step or one multiply add) and
// one output register. One word enters per cycle while out_ does not stall.
// The chain advances only when the output register is free or being
// drained, so a stall on out_ holds all.
// Reset (rst_n low, synchronous) empties the chain.
`timescale 1ns / 1ps
module typed_integer_alu #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [0] left_is_signed, [1] right_is_signed
  input  logic [135:0] in_tdata,  // [3:0] mode, [67:4] left_bits, [131:68] right_bits
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tuser,  // [0] result_is_signed
  output logic [71:0] out_tdata   // [63:0] result_bits, [66:64] trap_code
);
  localparam int unsigned W = DATA_WIDTH;
  localparam int unsigned N = DATA_WIDTH;

  tia_pkg::tia_ctl_t ctl_c [N+1];
  logic [W-1:0] a_c [N+1];
  logic [W-1:0] b_c [N+1];
  logic [W-1:0] q_c [N+1];
  logic [W-1:0] r_c [N+1];
  tia_pkg::tia_ctl_t f_ctl;
  tia_pkg::tia_ctl_t e_ctl;
  logic [W-1:0] f_a, f_b, f_q, f_r;
  logic en;

  logic        out_valid_r;
  logic        out_sgn_r;
  logic [W-1:0] out_bits_r;
  logic [2:0]  out_trap_r;
  logic [W-1:0] res_nxt;
  logic [W-1:0] qv, rv;

  assign en = !out_valid_r || out_tready;
  assign in_tready = en;

  tia_front #(.W(W)) u_front (
    .mode(in_tdata[3:0]), .ls(in_tuser[0]), .a(in_tdata[4 +: W]),
    .rs(in_tuser[1]), .b(in_tdata[68 +: W]),
    .ctl(f_ctl), .a_o(f_a), .b_o(f_b), .q_o(f_q), .r_o(f_r)
  );

  // entry control with the input valid folded in
  always_comb begin
    e_ctl = f_ctl;
    e_ctl.valid = in_tvalid;
  end

  // entry register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c[0].valid <= 1'b0;
    end else if (en) begin
      ctl_c[0] <= e_ctl;
    end
    if (en) begin
      a_c[0] <= f_a;
      b_c[0] <= f_b;
      q_c[0] <= f_q;
      r_c[0] <= ((f_ctl.mode == tia_pkg::OP_DIV) || (f_ctl.mode == tia_pkg::OP_MOD))
                && f_ctl.trap == tia_pkg::T_OK ? '0 : f_r;
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    tia_cell #(.W(W), .K(k)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .ctl_i(ctl_c[k]), .a_i(a_c[k]), .b_i(b_c[k]), .q_i(q_c[k]), .r_i(r_c[k]),
      .ctl_o(ctl_c[k+1]), .a_o(a_c[k+1]), .b_o(b_c[k+1]),
      .q_o(q_c[k+1]), .r_o(r_c[k+1])
    );
  end

  // final sign fix and result select
  always_comb begin
    qv = ctl_c[N].neg_q ? ('0 - q_c[N]) : q_c[N];
    rv = ctl_c[N].neg_r ? ('0 - r_c[N]) : r_c[N];
    case (ctl_c[N].mode)
      tia_pkg::OP_MUL: res_nxt = q_c[N];
      tia_pkg::OP_DIV: res_nxt = qv;
      tia_pkg::OP_MOD: res_nxt = rv;
      default:         res_nxt = r_c[N];
    endcase
    if (ctl_c[N].trap != tia_pkg::T_OK) res_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_c[N].valid;
    end
    if (en) begin
      out_bits_r <= res_nxt;
      out_trap_r <= ctl_c[N].trap;
      out_sgn_r  <= (ctl_c[N].trap == tia_pkg::T_OK) &&
                    (ctl_c[N].is_signed || ctl_c[N].mode == tia_pkg::OP_LT ||
                     ctl_c[N].mode == tia_pkg::OP_GT || ctl_c[N].mode == tia_pkg::OP_EQ);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_sgn_r;
  assign out_tdata  = {5'd0, out_trap_r, 64'(out_bits_r)};

  // a trapped word carries zero data and unsigned type
  a_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[66:64] != tia_pkg::T_OK |-> out_tdata[63:0] == '0 && !out_tuser)
    else $error("trap with nonzero result");
  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");
  // ready follows output backpressure only
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");
endmodule

// ===== sv/tia_cell.sv =====
// One restoring-division / shift-add multiply step of the cell chain
`timescale 1ns / 1ps
module tia_cell #(
  parameter int unsigned W = 64,
  parameter int unsigned K = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  tia_pkg::tia_ctl_t ctl_i,
  input  logic [W-1:0]   a_i,      // dividend magnitude / multiplicand
  input  logic [W-1:0]   b_i,      // divisor magnitude / multiplier
  input  logic [W-1:0]   q_i,      // quotient bits / product
  input  logic [W-1:0]   r_i,      // partial remainder / early result
  output tia_pkg::tia_ctl_t ctl_o,
  output logic [W-1:0]   a_o,
  output logic [W-1:0]   b_o,
  output logic [W-1:0]   q_o,
  output logic [W-1:0]   r_o
);
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic [W-1:0] q_nxt;
  logic [W-1:0] r_nxt;
  logic         is_md;

  // bit K from the top for division, bit K for multiply
  always_comb begin
    is_md = (ctl_i.mode == tia_pkg::OP_DIV) || (ctl_i.mode == tia_pkg::OP_MOD);
    trial = {r_i, a_i[W-1-K]};
    diff  = trial - {1'b0, b_i};
    q_nxt = q_i;
    r_nxt = r_i;
    if (ctl_i.trap == tia_pkg::T_OK && is_md) begin
      if (!diff[W]) begin
        r_nxt = diff[W-1:0];
        q_nxt[W-1-K] = 1'b1;
      end else begin
        r_nxt = trial[W-1:0];
      end
    end else if (ctl_i.trap == tia_pkg::T_OK && ctl_i.mode == tia_pkg::OP_MUL) begin
      if (b_i[K]) q_nxt = q_i + (a_i << K);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o.valid <= 1'b0;
    end else if (en) begin
      ctl_o <= ctl_i;
    end
    if (en) begin
      a_o <= a_i;
      b_o <= b_i;
      q_o <= q_nxt;
      r_o <= r_nxt;
    end
  end
endmodule

// ===== sv/tia_front.sv =====
// Entry logic: type conversion, traps and the operations that need no cell steps
`timescale 1ns / 1ps
module tia_front #(
  parameter int unsigned W = 64
) (
  input  logic [tia_pkg::OpW-1:0] mode,
  input  logic          ls,
  input  logic [W-1:0]  a,
  input  logic          rs,
  input  logic [W-1:0]  b,
  output tia_pkg::tia_ctl_t ctl,
  output logic [W-1:0]  a_o,
  output logic [W-1:0]  b_o,
  output logic [W-1:0]  q_o,
  output logic [W-1:0]  r_o
);
  logic [W-1:0] x;
  logic [W-1:0] y;
  logic [W-1:0] one;

  always_comb begin
    x   = ls ? (a ^ {1'b1, {(W-1){1'b0}}}) : a;
    y   = ls ? (b ^ {1'b1, {(W-1){1'b0}}}) : b;
    one = {{(W-1){1'b0}}, 1'b1};
    ctl.valid     = 1'b1;
    ctl.mode      = mode;
    ctl.is_signed = ls;
    ctl.neg_q     = 1'b0;
    ctl.neg_r     = 1'b0;
    ctl.trap      = tia_pkg::T_OK;
    a_o = a;
    b_o = b;
    q_o = '0;
    r_o = '0;
    if (mode == tia_pkg::OP_NEG) begin
      if (!ls) ctl.trap = tia_pkg::T_MINUS_U;
      else r_o = '0 - a;
    end else if (rs != ls && ls && b[W-1]) begin
      ctl.trap = tia_pkg::T_TOO_LARGE;
    end else if (rs != ls && !ls && b[W-1]) begin
      ctl.trap = tia_pkg::T_NEG_TO_U;
    end else begin
      case (mode)
        tia_pkg::OP_ADD: r_o = a + b;
        tia_pkg::OP_SUB: begin
          if (!ls && b > a) ctl.trap = tia_pkg::T_U_UNDER;
          else r_o = a - b;
        end
        tia_pkg::OP_MUL: ;
        tia_pkg::OP_DIV, tia_pkg::OP_MOD: begin
          if (b == '0) begin
            ctl.trap = (mode == tia_pkg::OP_DIV) ? tia_pkg::T_DIV_ZERO
                                                 : tia_pkg::T_MOD_ZERO;
          end else begin
            a_o = (ls && a[W-1]) ? ('0 - a) : a;
            b_o = (ls && b[W-1]) ? ('0 - b) : b;
            ctl.neg_q = ls && (a[W-1] ^ b[W-1]);
            ctl.neg_r = ls && a[W-1];
          end
        end
        tia_pkg::OP_LT: r_o = (x < y) ? one : '0;
        tia_pkg::OP_GT: r_o = (x > y) ? one : '0;
        tia_pkg::OP_EQ: r_o = (x == y) ? one : '0;
        default: ctl.trap = tia_pkg::T_BAD_OP;
      endcase
    end
  end
endmodule
